// File: design/rpgs_pkg.sv
`timescale 1ns / 1ps

package rpgs_pkg;

  // Default sizing
  localparam int DEF_MAX_ALLELES = 256;
  localparam int DEF_PROB_BITS   = 16;

  // Input beat opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_SIM  = 1'b1;

  // Configuration register indexes
  localparam int          CFG_IDX_W  = 1;
  localparam logic [0:0]  REG_K_NONE = 1'b0;
  localparam logic [0:0]  REG_K_ONE  = 1'b1;

  // IBD state codes
  localparam logic [1:0] IBD_NONE = 2'd0;
  localparam logic [1:0] IBD_ONE  = 2'd1;
  localparam logic [1:0] IBD_TWO  = 2'd2;

  // Number of allele draws walked in parallel
  localparam int NUM_DRAWS = 4;

  // Microprogram step addresses
  localparam int         STEP_W     = 2;
  localparam logic [1:0] STEP_WAIT  = 2'd0;
  localparam logic [1:0] STEP_ISSUE = 2'd1;
  localparam logic [1:0] STEP_WALK  = 2'd2;
  localparam logic [1:0] STEP_EMIT  = 2'd3;

  // Jump conditions: take the target when true, otherwise hold the step
  localparam int         COND_W       = 2;
  localparam logic [1:0] COND_ALWAYS  = 2'd0;
  localparam logic [1:0] COND_SIM     = 2'd1;
  localparam logic [1:0] COND_DONE    = 2'd2;
  localparam logic [1:0] COND_OUTFREE = 2'd3;

  typedef struct packed {
    logic              take_in;
    logic              issue;
    logic              walk;
    logic              emit;
    logic [COND_W-1:0] cond;
    logic [STEP_W-1:0] target;
  } ctrl_t;

  typedef struct packed {
    logic sim_go;
    logic walk_done;
    logic out_free;
  } status_t;

  // Control store
  function automatic ctrl_t ucode_word(input logic [STEP_W-1:0] step);
    ctrl_t w;
    w = '0;
    case (step)
      STEP_WAIT: begin
        w.take_in = 1'b1;
        w.cond    = COND_SIM;
        w.target  = STEP_ISSUE;
      end
      STEP_ISSUE: begin
        w.issue  = 1'b1;
        w.cond   = COND_ALWAYS;
        w.target = STEP_WALK;
      end
      STEP_WALK: begin
        w.issue  = 1'b1;
        w.walk   = 1'b1;
        w.cond   = COND_DONE;
        w.target = STEP_EMIT;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.cond   = COND_OUTFREE;
        w.target = STEP_WAIT;
      end
      default: begin
        w.cond   = COND_ALWAYS;
        w.target = STEP_WAIT;
      end
    endcase
    return w;
  endfunction

endpackage

// File: design/related_pair_genotype_sampler_unit.sv
`timescale 1ns / 1ps

// Related-pair genotype sampler. A load beat (opcode 0) writes one entry of
// the allele frequency table; a table entry must be written before any
// locus reads it. A simulate beat (opcode 1) picks the IBD state from u_ibd
// against k_none and k_none + k_one, then walks the locus's cumulative
// frequencies one allele per cycle through the single read port of the
// frequency RAM, resolving all needed draws in the same pass. It occupies
// the block through the issue, walk and emit steps; the walk runs up to the
// last allele any needed draw stops at, at most the allele count, and the
// result beat may wait on out_stall. Inputs are stalled meanwhile. k_none
// and k_one are written through the cfg port; the user must write them only
// while the block is idle, as the block itself does not enforce it.
module related_pair_genotype_sampler_unit #(
  parameter int MAX_ALLELES = rpgs_pkg::DEF_MAX_ALLELES,
  parameter int PROB_BITS   = rpgs_pkg::DEF_PROB_BITS,
  localparam int IDX_W = (MAX_ALLELES > 1) ? $clog2(MAX_ALLELES) : 1,
  localparam int CNT_W = $clog2(MAX_ALLELES + 1),
  localparam int FRQ_W = PROB_BITS + 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [rpgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [FRQ_W-1:0]               cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           in_opcode,
  input  logic [IDX_W-1:0]               in_table_index,
  input  logic [FRQ_W-1:0]               in_frequency,
  input  logic [IDX_W-1:0]               in_locus_start,
  input  logic [CNT_W-1:0]               in_allele_count,
  input  logic [PROB_BITS-1:0]           in_u_ibd,
  input  logic [PROB_BITS-1:0]           in_u_draw1,
  input  logic [PROB_BITS-1:0]           in_u_draw2,
  input  logic [PROB_BITS-1:0]           in_u_draw3,
  input  logic [PROB_BITS-1:0]           in_u_draw4,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [1:0]                     out_ibd_state,
  output logic [IDX_W-1:0]               out_first_allele_a,
  output logic [IDX_W-1:0]               out_first_allele_b,
  output logic [IDX_W-1:0]               out_second_allele_a,
  output logic [IDX_W-1:0]               out_second_allele_b
);

  localparam logic [FRQ_W-1:0] K_NONE_RST = FRQ_W'(1) << PROB_BITS;

  logic [FRQ_W-1:0]  k_none_r;
  logic [FRQ_W-1:0]  k_one_r;
  rpgs_pkg::ctrl_t   ctrl;
  rpgs_pkg::status_t status;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_none_r <= K_NONE_RST;
      k_one_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        rpgs_pkg::REG_K_NONE: k_none_r <= cfg_data;
        rpgs_pkg::REG_K_ONE:  k_one_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold off input beats outside the wait step
  assign in_stall = !ctrl.take_in;

  rpgs_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .status(status),
    .ctrl  (ctrl)
  );

  rpgs_dpath #(
    .MAX_ALLELES(MAX_ALLELES),
    .PROB_BITS  (PROB_BITS)
  ) u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .status             (status),
    .k_none             (k_none_r),
    .k_one              (k_one_r),
    .in_valid           (in_valid),
    .in_opcode          (in_opcode),
    .in_table_index     (in_table_index),
    .in_frequency       (in_frequency),
    .in_locus_start     (in_locus_start),
    .in_allele_count    (in_allele_count),
    .in_u_ibd           (in_u_ibd),
    .in_u_draw1         (in_u_draw1),
    .in_u_draw2         (in_u_draw2),
    .in_u_draw3         (in_u_draw3),
    .in_u_draw4         (in_u_draw4),
    .out_stall          (out_stall),
    .out_valid          (out_valid),
    .out_ibd_state      (out_ibd_state),
    .out_first_allele_a (out_first_allele_a),
    .out_first_allele_b (out_first_allele_b),
    .out_second_allele_a(out_second_allele_a),
    .out_second_allele_b(out_second_allele_b)
  );

endmodule

// File: design/rpgs_ram.sv
`timescale 1ns / 1ps

module rpgs_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/rpgs_useq.sv
`timescale 1ns / 1ps

module rpgs_useq (
  input  logic             clk,
  input  logic             rst_n,
  input  rpgs_pkg::status_t status,
  output rpgs_pkg::ctrl_t   ctrl
);

  logic [rpgs_pkg::STEP_W-1:0] step_r;
  logic [rpgs_pkg::STEP_W-1:0] step_nxt;
  logic                        jump;

  // Fetch the control word of the current step
  assign ctrl = rpgs_pkg::ucode_word(step_r);

  // Evaluate the jump condition
  always_comb begin
    case (ctrl.cond)
      rpgs_pkg::COND_ALWAYS:  jump = 1'b1;
      rpgs_pkg::COND_SIM:     jump = status.sim_go;
      rpgs_pkg::COND_DONE:    jump = status.walk_done;
      rpgs_pkg::COND_OUTFREE: jump = status.out_free;
      default:                jump = 1'b1;
    endcase
    step_nxt = jump ? ctrl.target : step_r;
  end

  // Advance the step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= rpgs_pkg::STEP_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// File: design/rpgs_dpath.sv
`timescale 1ns / 1ps

module rpgs_dpath #(
  parameter int MAX_ALLELES = rpgs_pkg::DEF_MAX_ALLELES,
  parameter int PROB_BITS   = rpgs_pkg::DEF_PROB_BITS,
  localparam int IDX_W = (MAX_ALLELES > 1) ? $clog2(MAX_ALLELES) : 1,
  localparam int CNT_W = $clog2(MAX_ALLELES + 1),
  localparam int FRQ_W = PROB_BITS + 1
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  rpgs_pkg::ctrl_t      ctrl,
  output rpgs_pkg::status_t    status,
  input  logic [FRQ_W-1:0]     k_none,
  input  logic [FRQ_W-1:0]     k_one,
  input  logic                 in_valid,
  input  logic                 in_opcode,
  input  logic [IDX_W-1:0]     in_table_index,
  input  logic [FRQ_W-1:0]     in_frequency,
  input  logic [IDX_W-1:0]     in_locus_start,
  input  logic [CNT_W-1:0]     in_allele_count,
  input  logic [PROB_BITS-1:0] in_u_ibd,
  input  logic [PROB_BITS-1:0] in_u_draw1,
  input  logic [PROB_BITS-1:0] in_u_draw2,
  input  logic [PROB_BITS-1:0] in_u_draw3,
  input  logic [PROB_BITS-1:0] in_u_draw4,
  input  logic                 out_stall,
  output logic                 out_valid,
  output logic [1:0]           out_ibd_state,
  output logic [IDX_W-1:0]     out_first_allele_a,
  output logic [IDX_W-1:0]     out_first_allele_b,
  output logic [IDX_W-1:0]     out_second_allele_a,
  output logic [IDX_W-1:0]     out_second_allele_b
);

  localparam int ND    = rpgs_pkg::NUM_DRAWS;
  localparam int CUM_W = FRQ_W + IDX_W;
  localparam logic [IDX_W:0]   MAX_EXT  = (IDX_W + 1)'(MAX_ALLELES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ALLELES - 1);
  localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_ALLELES);

  logic                 accept;
  logic                 load_go;
  logic                 sim_go;
  logic [IDX_W-1:0]     wr_idx;
  logic [IDX_W-1:0]     start_idx;
  logic [IDX_W:0]       tmp_ext;
  logic [IDX_W:0]       st_ext;
  logic [CNT_W-1:0]     cnt_m1;
  logic [IDX_W-1:0]     last_in;
  logic [FRQ_W:0]       k_sum;
  logic [1:0]           ibd_in;
  logic [ND-1:0]        done_in;
  logic [FRQ_W-1:0]     rd_data;

  logic [IDX_W-1:0]     addr_r;
  logic [IDX_W-1:0]     ev_addr_r;
  logic [IDX_W-1:0]     ev_cnt_r;
  logic [IDX_W-1:0]     last_r;
  logic [CUM_W-1:0]     cum_r;
  logic [CUM_W-1:0]     cum_nxt;
  logic [1:0]           ibd_r;
  logic [PROB_BITS-1:0] u_r    [ND];
  logic [IDX_W-1:0]     pick_r [ND];
  logic [ND-1:0]        done_r;
  logic [ND-1:0]        hit;
  logic                 last_hit;
  logic                 out_free;
  logic                 out_valid_r;

  assign accept  = ctrl.take_in && in_valid;
  assign load_go = accept && (in_opcode == rpgs_pkg::OP_LOAD);
  assign sim_go  = accept && (in_opcode == rpgs_pkg::OP_SIM);

  // Wrap table indexes into the table
  always_comb begin
    tmp_ext = {1'b0, in_table_index};
    if (tmp_ext >= MAX_EXT) begin
      tmp_ext = tmp_ext - MAX_EXT;
    end
    wr_idx = tmp_ext[IDX_W-1:0];
    st_ext = {1'b0, in_locus_start};
    if (st_ext >= MAX_EXT) begin
      st_ext = st_ext - MAX_EXT;
    end
    start_idx = st_ext[IDX_W-1:0];
  end

  // Clamp the allele count and take the last position
  always_comb begin
    cnt_m1 = in_allele_count - CNT_W'(1);
    if (in_allele_count == '0) begin
      last_in = '0;
    end else if (in_allele_count > MAX_CNT) begin
      last_in = LAST_IDX;
    end else begin
      last_in = cnt_m1[IDX_W-1:0];
    end
  end

  // Choose the IBD state and the draws that must be walked
  always_comb begin
    k_sum = {1'b0, k_none} + {1'b0, k_one};
    if ({1'b0, in_u_ibd} < k_none) begin
      ibd_in = rpgs_pkg::IBD_NONE;
    end else if ({2'b00, in_u_ibd} < k_sum) begin
      ibd_in = rpgs_pkg::IBD_ONE;
    end else begin
      ibd_in = rpgs_pkg::IBD_TWO;
    end
    case (ibd_in)
      rpgs_pkg::IBD_NONE: done_in = 4'b0000;
      rpgs_pkg::IBD_ONE:  done_in = 4'b1000;
      default:            done_in = 4'b1100;
    endcase
  end

  rpgs_ram #(
    .WIDTH(FRQ_W),
    .DEPTH(MAX_ALLELES)
  ) u_freq_ram (
    .clk  (clk),
    .we   (load_go),
    .waddr(wr_idx),
    .wdata(in_frequency),
    .raddr(addr_r),
    .rdata(rd_data)
  );

  // Compare every draw against the running sum
  always_comb begin
    cum_nxt  = cum_r + CUM_W'(rd_data);
    last_hit = (ev_cnt_r == last_r);
    for (int j = 0; j < ND; j++) begin
      hit[j] = (CUM_W'(u_r[j]) < cum_nxt) || last_hit;
    end
  end

  // Walk registers
  always_ff @(posedge clk) begin
    if (sim_go) begin
      addr_r  <= start_idx;
      last_r  <= last_in;
      ibd_r   <= ibd_in;
      done_r  <= done_in;
      u_r[0]  <= in_u_draw1;
      u_r[1]  <= in_u_draw2;
      u_r[2]  <= in_u_draw3;
      u_r[3]  <= in_u_draw4;
    end
    if (ctrl.issue) begin
      addr_r    <= (addr_r == LAST_IDX) ? '0 : addr_r + IDX_W'(1);
      ev_addr_r <= addr_r;
    end
    if (ctrl.issue && !ctrl.walk) begin
      ev_cnt_r <= '0;
      cum_r    <= '0;
    end
    if (ctrl.walk) begin
      ev_cnt_r <= ev_cnt_r + IDX_W'(1);
      cum_r    <= cum_nxt;
      done_r   <= done_r | hit;
      for (int j = 0; j < ND; j++) begin
        if (!done_r[j] && hit[j]) begin
          pick_r[j] <= ev_addr_r;
        end
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  // Output register: load on emit, drop once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.emit && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit && out_free) begin
      out_ibd_state      <= ibd_r;
      out_first_allele_a <= pick_r[0];
      out_first_allele_b <= pick_r[1];
      if (ibd_r == rpgs_pkg::IBD_NONE) begin
        out_second_allele_a <= pick_r[2];
        out_second_allele_b <= pick_r[3];
      end else if (ibd_r == rpgs_pkg::IBD_ONE) begin
        out_second_allele_a <= pick_r[0];
        out_second_allele_b <= pick_r[2];
      end else begin
        out_second_allele_a <= pick_r[0];
        out_second_allele_b <= pick_r[1];
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign status.sim_go    = sim_go;
  assign status.walk_done = &(done_r | hit);
  assign status.out_free  = out_free;

endmodule

// File: design/rpgs_checker.sv
`timescale 1ns / 1ps

module rpgs_checker #(
  parameter int MAX_ALLELES = rpgs_pkg::DEF_MAX_ALLELES,
  parameter int PROB_BITS   = rpgs_pkg::DEF_PROB_BITS,
  localparam int IDX_W = (MAX_ALLELES > 1) ? $clog2(MAX_ALLELES) : 1
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             in_opcode,
  input logic             out_valid,
  input logic             out_stall,
  input logic [1:0]       out_ibd_state,
  input logic [IDX_W-1:0] out_first_allele_a,
  input logic [IDX_W-1:0] out_first_allele_b,
  input logic [IDX_W-1:0] out_second_allele_a,
  input logic [IDX_W-1:0] out_second_allele_b
);

  // A stalled result beat stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // A simulate beat keeps the input stalled for the walk
  a_sim_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_opcode == rpgs_pkg::OP_SIM) |=> in_stall)
    else $error("input taken during a locus walk");

  // IBD state is one of the three legal values
  a_ibd_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ibd_state == rpgs_pkg::IBD_NONE) ||
                  (out_ibd_state == rpgs_pkg::IBD_ONE) ||
                  (out_ibd_state == rpgs_pkg::IBD_TWO))
    else $error("illegal IBD state");

  // One or two shared alleles: second individual reuses the first allele
  a_ibd_one: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_ibd_state != rpgs_pkg::IBD_NONE) |->
      out_second_allele_a == out_first_allele_a)
    else $error("shared allele not copied");

  // Two shared alleles: genotypes identical
  a_ibd_two: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_ibd_state == rpgs_pkg::IBD_TWO) |->
      out_second_allele_b == out_first_allele_b)
    else $error("second shared allele not copied");

endmodule

bind related_pair_genotype_sampler_unit rpgs_checker #(
  .MAX_ALLELES(MAX_ALLELES),
  .PROB_BITS  (PROB_BITS)
) u_rpgs_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .in_opcode          (in_opcode),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_ibd_state      (out_ibd_state),
  .out_first_allele_a (out_first_allele_a),
  .out_first_allele_b (out_first_allele_b),
  .out_second_allele_a(out_second_allele_a),
  .out_second_allele_b(out_second_allele_b)
);
